FILE: hdl/cpab_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpab_pkg
// Shared types, constants and helpers for the clipped premultiplied alpha
// blit: register map, coordinate widths and the size clamp.
// ----------------------------------------------------------------------------
package cpab_pkg;

   // largest surface dimension in pixels
   localparam int MAX_DIM = 4096;

   // register field widths
   localparam int POS_W   = 16;
   localparam int SIZE_W  = 13;
   localparam int COORD_W = 12;
   localparam int CSR_W   = 16;
   localparam int INDEX_W = 3;

   // opaque alpha / channel full scale
   localparam logic [7:0] BYTE_MAX = 8'hFF;

   // register map
   typedef enum logic [INDEX_W-1:0] {
      CSR_SOURCE_POS_X  = 3'd0,
      CSR_SOURCE_POS_Y  = 3'd1,
      CSR_SOURCE_WIDTH  = 3'd2,
      CSR_SOURCE_HEIGHT = 3'd3,
      CSR_DEST_WIDTH    = 3'd4,
      CSR_DEST_HEIGHT   = 3'd5
   } csr_index_type;

   // configuration register file
   typedef struct packed {
      logic [POS_W-1:0]  source_pos_x;
      logic [POS_W-1:0]  source_pos_y;
      logic [SIZE_W-1:0] source_width;
      logic [SIZE_W-1:0] source_height;
      logic [SIZE_W-1:0] dest_width;
      logic [SIZE_W-1:0] dest_height;
   } cfg_type;

   // scan position of the word being accepted
   typedef struct packed {
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
      logic               last;
   } scan_type;

   // one ARGB pixel
   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic [7:0] alpha;
   } pixel_type;

   // limit a size to MAX_DIM, and optionally raise zero to one
   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] size,
                                                    input logic floor_one);
      logic [SIZE_W-1:0] result;
      result = size;
      if (size > SIZE_W'(MAX_DIM)) begin
         result = SIZE_W'(MAX_DIM);
      end else if (floor_one && (size == '0)) begin
         result = SIZE_W'(1);
      end
      return result;
   endfunction

endpackage

FILE: hdl/clipped_premultiplied_alpha_blit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clipped_premultiplied_alpha_blit
// Premultiplied ARGB32 OVER blit of a positioned source onto a destination,
// clipped to the destination bounds.
// ----------------------------------------------------------------------------
// One word is taken per clock while req_ready is high; it passes the input
// register, which holds the pixel pair and its scan position, and then the
// result register, which holds the clipped coordinates and the blended bytes.
// Between the two registers each channel has one byte multiplier and a
// divide-by-255 correction. Both registers advance whenever the result register
// is empty or being taken, so the sustained rate is one word per cycle. While
// the receiver holds a result, one more word can still enter the input
// register. New words stall only once both registers are full. The user writes
// registers through the csr port while no word is in flight; not enforced.
// ----------------------------------------------------------------------------
module clipped_premultiplied_alpha_blit
   import cpab_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // configuration
   input  logic               csr_write_en,
   input  logic [INDEX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]   csr_wdata,
   // input words
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_src_blue,
   input  logic [7:0]         req_src_green,
   input  logic [7:0]         req_src_red,
   input  logic [7:0]         req_src_alpha,
   input  logic [7:0]         req_dst_blue,
   input  logic [7:0]         req_dst_green,
   input  logic [7:0]         req_dst_red,
   input  logic [7:0]         req_dst_alpha,
   // result words
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_inside_res,
   output logic               rsp_write_enable,
   output logic [COORD_W-1:0] rsp_dest_x,
   output logic [COORD_W-1:0] rsp_dest_y,
   output logic [7:0]         rsp_out_blue,
   output logic [7:0]         rsp_out_green,
   output logic [7:0]         rsp_out_red,
   output logic [7:0]         rsp_out_alpha,
   output logic               rsp_last_pixel
);

   cfg_type            cfg_ff, cfg_in;
   scan_type           scan;

   logic               a_valid_ff, a_valid_in;
   pixel_type          a_src_ff, a_src_in;
   pixel_type          a_dst_ff, a_dst_in;
   scan_type           a_scan_ff, a_scan_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               inside_ff, inside_in;
   logic               write_ff, write_in;
   logic [COORD_W-1:0] dest_x_ff, dest_x_in;
   logic [COORD_W-1:0] dest_y_ff, dest_y_in;
   pixel_type          out_ff, out_in;
   logic               last_ff, last_in;

   logic               b_ready;
   logic               req_accept;
   logic [SIZE_W-1:0]  dest_w_lim;
   logic [SIZE_W-1:0]  dest_h_lim;
   logic signed [POS_W:0] pos_x;
   logic signed [POS_W:0] pos_y;
   logic signed [POS_W:0] dx;
   logic signed [POS_W:0] dy;
   logic               write_en;

   // configuration writes, unknown indexes ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_SOURCE_POS_X:  cfg_in.source_pos_x  = csr_wdata;
            CSR_SOURCE_POS_Y:  cfg_in.source_pos_y  = csr_wdata;
            CSR_SOURCE_WIDTH:  cfg_in.source_width  = csr_wdata[SIZE_W-1:0];
            CSR_SOURCE_HEIGHT: cfg_in.source_height = csr_wdata[SIZE_W-1:0];
            CSR_DEST_WIDTH:    cfg_in.dest_width    = csr_wdata[SIZE_W-1:0];
            CSR_DEST_HEIGHT:   cfg_in.dest_height   = csr_wdata[SIZE_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   // flow control
   assign b_ready    = !rsp_valid_ff || rsp_ready;
   assign req_ready  = !a_valid_ff || b_ready;
   assign req_accept = req_valid && req_ready;

   // raster position of the incoming word
   cpab_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .advance (req_accept),
      .scan    (scan)
   );

   // input register
   always_comb begin
      a_valid_in = a_valid_ff;
      a_src_in   = a_src_ff;
      a_dst_in   = a_dst_ff;
      a_scan_in  = a_scan_ff;
      if (req_accept) begin
         a_valid_in = 1'b1;
         a_src_in   = '{blue: req_src_blue, green: req_src_green,
                        red: req_src_red, alpha: req_src_alpha};
         a_dst_in   = '{blue: req_dst_blue, green: req_dst_green,
                        red: req_dst_red, alpha: req_dst_alpha};
         a_scan_in  = scan;
      end else if (b_ready) begin
         a_valid_in = 1'b0;
      end
   end

   // destination coordinates and clipping
   assign dest_w_lim = clamp_size(cfg_ff.dest_width, 1'b0);
   assign dest_h_lim = clamp_size(cfg_ff.dest_height, 1'b0);
   assign pos_x      = $signed({cfg_ff.source_pos_x[POS_W-1], cfg_ff.source_pos_x});
   assign pos_y      = $signed({cfg_ff.source_pos_y[POS_W-1], cfg_ff.source_pos_y});
   assign dx         = pos_x + $signed({5'b00000, a_scan_ff.column});
   assign dy         = pos_y + $signed({5'b00000, a_scan_ff.row});
   assign inside_in  = !dx[POS_W] && !dy[POS_W]
                     && (dx[POS_W-1:0] < {3'b000, dest_w_lim})
                     && (dy[POS_W-1:0] < {3'b000, dest_h_lim});
   assign write_en   = inside_in && (a_src_ff.alpha != 8'h00);
   assign write_in   = write_en;
   assign dest_x_in  = inside_in ? dx[COORD_W-1:0] : '0;
   assign dest_y_in  = inside_in ? dy[COORD_W-1:0] : '0;
   assign last_in    = a_scan_ff.last;

   // channel blends
   cpab_blend u_blend_blue (
      .src_byte (a_src_ff.blue),
      .dst_byte (a_dst_ff.blue),
      .alpha    (a_src_ff.alpha),
      .write_en (write_en),
      .out_byte (out_in.blue)
   );

   cpab_blend u_blend_green (
      .src_byte (a_src_ff.green),
      .dst_byte (a_dst_ff.green),
      .alpha    (a_src_ff.alpha),
      .write_en (write_en),
      .out_byte (out_in.green)
   );

   cpab_blend u_blend_red (
      .src_byte (a_src_ff.red),
      .dst_byte (a_dst_ff.red),
      .alpha    (a_src_ff.alpha),
      .write_en (write_en),
      .out_byte (out_in.red)
   );

   cpab_blend u_blend_alpha (
      .src_byte (a_src_ff.alpha),
      .dst_byte (a_dst_ff.alpha),
      .alpha    (a_src_ff.alpha),
      .write_en (write_en),
      .out_byte (out_in.alpha)
   );

   // result register valid
   assign rsp_valid_in = b_ready ? a_valid_ff : rsp_valid_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '{source_pos_x: '0, source_pos_y: '0,
                           source_width: SIZE_W'(1), source_height: SIZE_W'(1),
                           dest_width: SIZE_W'(1), dest_height: SIZE_W'(1)};
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      a_src_ff  <= a_src_in;
      a_dst_ff  <= a_dst_in;
      a_scan_ff <= a_scan_in;
      if (b_ready && a_valid_ff) begin
         inside_ff <= inside_in;
         write_ff  <= write_in;
         dest_x_ff <= dest_x_in;
         dest_y_ff <= dest_y_in;
         out_ff    <= out_in;
         last_ff   <= last_in;
      end
   end

   // result ports
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_inside_res   = inside_ff;
   assign rsp_write_enable = write_ff;
   assign rsp_dest_x       = dest_x_ff;
   assign rsp_dest_y       = dest_y_ff;
   assign rsp_out_blue     = out_ff.blue;
   assign rsp_out_green    = out_ff.green;
   assign rsp_out_red      = out_ff.red;
   assign rsp_out_alpha    = out_ff.alpha;
   assign rsp_last_pixel   = last_ff;

endmodule

FILE: hdl/cpab_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpab_blend
// One channel of premultiplied OVER: src + floor(dst * (255 - alpha) / 255),
// wrapping to a byte, or the destination byte when no write happens.
// ----------------------------------------------------------------------------
module cpab_blend
   import cpab_pkg::*;
(
   input  logic [7:0] src_byte,
   input  logic [7:0] dst_byte,
   input  logic [7:0] alpha,
   input  logic       write_en,
   output logic [7:0] out_byte
);

   logic [7:0]         inv_alpha;
   logic [15:0]        product;
   logic [16:0]        approx_sum;
   logic [8:0]         quot_est;
   logic signed [17:0] remainder;
   logic [8:0]         quot;
   logic [7:0]         sum;

   // scaled destination
   assign inv_alpha = BYTE_MAX - alpha;
   assign product   = 16'(dst_byte) * 16'(inv_alpha);

   // divide by 255: shift-add estimate, then one step of correction
   assign approx_sum = {1'b0, product} + 17'(product[15:8]) + 17'd1;
   assign quot_est   = approx_sum[16:8];
   assign remainder  = $signed({2'b00, product}) - $signed({1'b0, quot_est, 8'h00})
                     + $signed({9'h000, quot_est});

   always_comb begin
      quot = quot_est;
      if (remainder < 0) begin
         quot = quot_est - 9'd1;
      end else if (remainder >= 18'sd255) begin
         quot = quot_est + 9'd1;
      end
   end

   // add source, wrap to a byte
   assign sum      = src_byte + quot[7:0];
   assign out_byte = write_en ? sum : dst_byte;

endmodule

FILE: hdl/cpab_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpab_scan
// Column and row counters over the source surface in raster order; flags
// the final pixel and wraps at the clamped source size.
// ----------------------------------------------------------------------------
module cpab_scan
   import cpab_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     advance,
   output scan_type scan
);

   logic [COORD_W-1:0] column_ff, column_in;
   logic [COORD_W-1:0] row_ff, row_in;
   logic [SIZE_W-1:0]  width_lim;
   logic [SIZE_W-1:0]  height_lim;
   logic [SIZE_W-1:0]  column_next;
   logic [SIZE_W-1:0]  row_next;
   logic               line_end;
   logic               frame_end;

   // end of line and end of surface
   assign width_lim   = clamp_size(cfg.source_width, 1'b1);
   assign height_lim  = clamp_size(cfg.source_height, 1'b1);
   assign column_next = {1'b0, column_ff} + SIZE_W'(1);
   assign row_next    = {1'b0, row_ff} + SIZE_W'(1);
   assign line_end    = column_next >= width_lim;
   assign frame_end   = line_end && (row_next >= height_lim);

   // counter update
   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      if (advance) begin
         if (line_end) begin
            column_in = '0;
            if (row_next >= height_lim) begin
               row_in = '0;
            end else begin
               row_in = row_next[COORD_W-1:0];
            end
         end else begin
            column_in = column_next[COORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= '0;
      end else begin
         column_ff <= column_in;
         row_ff    <= row_in;
      end
   end

   assign scan.column = column_ff;
   assign scan.row    = row_ff;
   assign scan.last   = frame_end;

endmodule

FILE: hdl/cpab_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpab_checker
// Port-level checks on the blit result channel, bound to the top level.
// ----------------------------------------------------------------------------
module cpab_checker
   import cpab_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_inside_res,
   input logic               rsp_write_enable,
   input logic [COORD_W-1:0] rsp_dest_x,
   input logic [COORD_W-1:0] rsp_dest_y,
   input logic [7:0]         rsp_out_blue,
   input logic               rsp_last_pixel
);

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_blue)
                                  && $stable(rsp_dest_x) && $stable(rsp_last_pixel))
      else $error("stalled result word changed");

   // a write only happens inside the destination
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_write_enable |-> rsp_inside_res)
      else $error("write enable outside destination");

   // clipped words report the origin
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_inside_res |-> (rsp_dest_x == '0) && (rsp_dest_y == '0))
      else $error("clipped word carries coordinates");

   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind clipped_premultiplied_alpha_blit cpab_checker u_cpab_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_inside_res   (rsp_inside_res),
   .rsp_write_enable (rsp_write_enable),
   .rsp_dest_x       (rsp_dest_x),
   .rsp_dest_y       (rsp_dest_y),
   .rsp_out_blue     (rsp_out_blue),
   .rsp_last_pixel   (rsp_last_pixel)
);

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the clipped premultiplied alpha blit. Words are
// streamed over a set of placements and surface sizes; every accepted word is
// run through a behavioral OVER compositor with its own scan counters, and
// each result word is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
   import cpab_pkg::*;

   localparam int HALF_PERIOD   = 6;
   localparam int RESET_CYCLES  = 9;
   localparam int IDLE_PERCENT  = 16;
   localparam int HOLD_CYCLES   = 80;
   localparam int SETTLE_CYCLES = 4;
   localparam int RANDOM_WORDS  = 500;
   localparam int LIMIT_CYCLES  = 200000;
   localparam int PRINT_LIMIT   = 40;

   // index past the end of the register map, writes are dropped
   localparam logic [INDEX_W-1:0] CSR_UNMAPPED = 3'd7;

   // expected contents of one result word
   typedef struct {
      logic               in_bounds;
      logic               writes;
      logic [COORD_W-1:0] dest_x;
      logic [COORD_W-1:0] dest_y;
      pixel_type          color;
      logic               last_word;
   } blit_result_type;

   // ------------------------------------------------------------------------
   // compositor model: placement registers, scan counters, pending results
   // ------------------------------------------------------------------------
   class over_blit_model;
      logic [POS_W-1:0]   pos_x, pos_y;
      logic [SIZE_W-1:0]  src_w, src_h, dst_w, dst_h;
      logic [COORD_W-1:0] column, row;
      blit_result_type    pending_pixels[$];
      int                 mismatches;

      function new();
         pos_x = '0;
         pos_y = '0;
         src_w = SIZE_W'(1);
         src_h = SIZE_W'(1);
         dst_w = SIZE_W'(1);
         dst_h = SIZE_W'(1);
         column = '0;
         row = '0;
         mismatches = 0;
      endfunction

      function void write_reg(logic [INDEX_W-1:0] idx, logic [CSR_W-1:0] value);
         case (idx)
            CSR_SOURCE_POS_X:  pos_x = value[POS_W-1:0];
            CSR_SOURCE_POS_Y:  pos_y = value[POS_W-1:0];
            CSR_SOURCE_WIDTH:  src_w = value[SIZE_W-1:0];
            CSR_SOURCE_HEIGHT: src_h = value[SIZE_W-1:0];
            CSR_DEST_WIDTH:    dst_w = value[SIZE_W-1:0];
            CSR_DEST_HEIGHT:   dst_h = value[SIZE_W-1:0];
            default: ;
         endcase
      endfunction

      // sizes saturate at the largest surface, zero optionally lifted
      function int limit_size(logic [SIZE_W-1:0] size, int lowest);
         int s;
         s = int'(size);
         if (s > MAX_DIM) s = MAX_DIM;
         if (s < lowest) s = lowest;
         return s;
      endfunction

      // src + floor(dst * (255 - alpha) / 255), wrapping to a byte
      function logic [7:0] over_channel(logic [7:0] s, logic [7:0] d, logic [7:0] a);
         int sum;
         sum = int'(s) + (int'(d) * (int'(BYTE_MAX) - int'(a))) / int'(BYTE_MAX);
         return sum[7:0];
      endfunction

      function int pending();
         return pending_pixels.size();
      endfunction

      function void note_pixel(pixel_type src, pixel_type dst);
         int              sw, sh, dw, dh, dx, dy;
         blit_result_type r;
         sw = limit_size(src_w, 1);
         sh = limit_size(src_h, 1);
         dw = limit_size(dst_w, 0);
         dh = limit_size(dst_h, 0);
         dx = int'($signed(pos_x)) + int'(column);
         dy = int'($signed(pos_y)) + int'(row);

         r.in_bounds = (dx >= 0) && (dy >= 0) && (dx < dw) && (dy < dh);
         r.writes = r.in_bounds && (src.alpha != 8'h00);
         r.dest_x = r.in_bounds ? dx[COORD_W-1:0] : '0;
         r.dest_y = r.in_bounds ? dy[COORD_W-1:0] : '0;
         r.last_word = 1'b0;

         // destination passes through unless the pixel is written
         r.color = dst;
         if (r.writes) begin
            if (src.alpha == BYTE_MAX) begin
               r.color = src;
            end else begin
               r.color.blue  = over_channel(src.blue, dst.blue, src.alpha);
               r.color.green = over_channel(src.green, dst.green, src.alpha);
               r.color.red   = over_channel(src.red, dst.red, src.alpha);
               r.color.alpha = over_channel(src.alpha, dst.alpha, src.alpha);
            end
         end

         // raster scan, a counter past a shrunk size wraps at once
         if (int'(column) + 1 >= sw) begin
            column = '0;
            if (int'(row) + 1 >= sh) begin
               row = '0;
               r.last_word = 1'b1;
            end else begin
               row = row + 1'b1;
            end
         end else begin
            column = column + 1'b1;
         end
         pending_pixels.push_back(r);
      endfunction

      task report(string what, int unsigned got, int unsigned want);
         if (mismatches < PRINT_LIMIT) begin
            $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
         end
         mismatches++;
      endtask

      task check_result(blit_result_type got);
         blit_result_type want;
         if (pending_pixels.size() == 0) begin
            report("result word with none pending", 1, 0);
            return;
         end
         want = pending_pixels.pop_front();
         if (got.in_bounds !== want.in_bounds)
            report("inside_res", got.in_bounds, want.in_bounds);
         if (got.writes !== want.writes)
            report("write_enable", got.writes, want.writes);
         if (got.dest_x !== want.dest_x)
            report("dest_x", got.dest_x, want.dest_x);
         if (got.dest_y !== want.dest_y)
            report("dest_y", got.dest_y, want.dest_y);
         if (got.color.blue !== want.color.blue)
            report("out_blue", got.color.blue, want.color.blue);
         if (got.color.green !== want.color.green)
            report("out_green", got.color.green, want.color.green);
         if (got.color.red !== want.color.red)
            report("out_red", got.color.red, want.color.red);
         if (got.color.alpha !== want.color.alpha)
            report("out_alpha", got.color.alpha, want.color.alpha);
         if (got.last_word !== want.last_word)
            report("last_pixel", got.last_word, want.last_word);
      endtask
   endclass

   // ------------------------------------------------------------------------
   // block under test and its drive signals
   // ------------------------------------------------------------------------
   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_write_en = 1'b0;
   logic [INDEX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]   csr_wdata = '0;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [7:0]         req_src_blue = '0;
   logic [7:0]         req_src_green = '0;
   logic [7:0]         req_src_red = '0;
   logic [7:0]         req_src_alpha = '0;
   logic [7:0]         req_dst_blue = '0;
   logic [7:0]         req_dst_green = '0;
   logic [7:0]         req_dst_red = '0;
   logic [7:0]         req_dst_alpha = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_inside_res;
   logic               rsp_write_enable;
   logic [COORD_W-1:0] rsp_dest_x;
   logic [COORD_W-1:0] rsp_dest_y;
   logic [7:0]         rsp_out_blue;
   logic [7:0]         rsp_out_green;
   logic [7:0]         rsp_out_red;
   logic [7:0]         rsp_out_alpha;
   logic               rsp_last_pixel;

   over_blit_model board;
   bit             calm = 1'b0;
   bit             hold_off_req = 1'b0;

   clipped_premultiplied_alpha_blit dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_src_blue     (req_src_blue),
      .req_src_green    (req_src_green),
      .req_src_red      (req_src_red),
      .req_src_alpha    (req_src_alpha),
      .req_dst_blue     (req_dst_blue),
      .req_dst_green    (req_dst_green),
      .req_dst_red      (req_dst_red),
      .req_dst_alpha    (req_dst_alpha),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_inside_res   (rsp_inside_res),
      .rsp_write_enable (rsp_write_enable),
      .rsp_dest_x       (rsp_dest_x),
      .rsp_dest_y       (rsp_dest_y),
      .rsp_out_blue     (rsp_out_blue),
      .rsp_out_green    (rsp_out_green),
      .rsp_out_red      (rsp_out_red),
      .rsp_out_alpha    (rsp_out_alpha),
      .rsp_last_pixel   (rsp_last_pixel)
   );

   // clock
   always #(HALF_PERIOD) clock = ~clock;

   // run limit
   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("status: fail");
      $finish;
   end

   // result side: random stalls plus one long hold-off on request
   initial begin : result_sink
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // result words are checked midway through the cycle that accepts them
   always @(negedge clock) begin : result_monitor
      blit_result_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.in_bounds = rsp_inside_res;
         got.writes = rsp_write_enable;
         got.dest_x = rsp_dest_x;
         got.dest_y = rsp_dest_y;
         got.color.blue = rsp_out_blue;
         got.color.green = rsp_out_green;
         got.color.red = rsp_out_red;
         got.color.alpha = rsp_out_alpha;
         got.last_word = rsp_last_pixel;
         board.check_result(got);
      end
   end

   // ------------------------------------------------------------------------
   // drive tasks, all entered and left on a rising edge
   // ------------------------------------------------------------------------
   task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [CSR_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      board.write_reg(idx, value);
   endtask

   task automatic csr_done();
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // stop offering and let every pending result drain out
   task automatic quiesce();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_geometry(input logic [CSR_W-1:0] px, input logic [CSR_W-1:0] py,
                               input logic [CSR_W-1:0] sw, input logic [CSR_W-1:0] sh,
                               input logic [CSR_W-1:0] dw, input logic [CSR_W-1:0] dh);
      quiesce();
      write_reg(CSR_SOURCE_POS_X, px);
      write_reg(CSR_SOURCE_POS_Y, py);
      write_reg(CSR_SOURCE_WIDTH, sw);
      write_reg(CSR_SOURCE_HEIGHT, sh);
      write_reg(CSR_DEST_WIDTH, dw);
      write_reg(CSR_DEST_HEIGHT, dh);
      csr_done();
   endtask

   // offer one word, optionally after a short gap, hold until taken
   task automatic offer(input pixel_type src, input pixel_type dst);
      bit taken;
      if (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_src_blue <= src.blue;
      req_src_green <= src.green;
      req_src_red <= src.red;
      req_src_alpha <= src.alpha;
      req_dst_blue <= dst.blue;
      req_dst_green <= dst.green;
      req_dst_red <= dst.red;
      req_dst_alpha <= dst.alpha;
      do begin
         @(negedge clock);
         taken = req_ready;
         if (taken) board.note_pixel(src, dst);
         @(posedge clock);
      end while (!taken);
   endtask

   // random pixel pair, alpha leaning toward its special values
   task automatic offer_random();
      pixel_type src, dst;
      src = $urandom;
      dst = $urandom;
      case ($urandom_range(9))
         0: src.alpha = 8'h00;
         1: src.alpha = BYTE_MAX;
         2: src.alpha = 8'h01;
         3: src.alpha = 8'hFE;
         default: ;
      endcase
      offer(src, dst);
   endtask

   function automatic logic [CSR_W-1:0] pick_size();
      case ($urandom_range(11))
         0: return '0;
         1: return CSR_W'(MAX_DIM);
         2: return CSR_W'($urandom);   // bits above the register and oversize values
         default: return CSR_W'($urandom_range(1, 6));
      endcase
   endfunction

   function automatic logic [CSR_W-1:0] pick_offset(bit far);
      case ($urandom_range(9))
         0: return CSR_W'($urandom);
         1: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
         default: begin
            if (far) return CSR_W'(MAX_DIM - int'($urandom_range(1, 6)));
            return CSR_W'(int'($urandom_range(8)) - 4);
         end
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   initial begin : stimulus
      int phase;
      int sent;
      int count;
      bit far;
      logic [CSR_W-1:0] dw, dh;

      board = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset placement: one pixel at the origin; a write past the map is dropped
      write_reg(CSR_UNMAPPED, 16'hFFFF);
      csr_done();
      // words are {blue, green, red, alpha}
      offer(32'h0000_0000, 32'hFFFF_FFFF);   // transparent, destination kept
      offer(32'hFFFF_FFFF, 32'h0000_0000);   // opaque copy
      offer(32'hFFFF_FF01, 32'hFFFF_FFFF);   // nearly clear, sum wraps
      offer(32'h0000_00FE, 32'hFFFF_FFFF);
      offer(32'h5555_5580, 32'hAAAA_AAAA);

      // clipped on all four sides of a one pixel destination
      set_geometry(16'hFFFF, 16'hFFFF, 16'd3, 16'd3, 16'd1, 16'd1);
      repeat (9) offer_random();

      // zero source size acts as one, zero destination takes nothing
      set_geometry(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      offer_random();

      // oversize destination, far right and bottom edges
      set_geometry(16'd4093, 16'd4095, 16'd4, 16'd1, 16'h1FFF, 16'hFFFF);
      repeat (4) offer_random();

      // positions at the signed extremes
      set_geometry(16'h8000, 16'h7FFF, 16'd1, 16'd1, 16'd4096, 16'd4096);
      offer_random();

      // width shrinks mid-line so the column counter is past the new end
      set_geometry(16'd0, 16'd0, 16'd4, 16'd2, 16'd8, 16'd8);
      repeat (3) offer_random();
      quiesce();
      write_reg(CSR_SOURCE_WIDTH, 16'd2);
      csr_done();
      repeat (2) offer_random();

      // random placements and sizes
      phase = 0;
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         far = ($urandom_range(4) == 0);
         dw = far ? ($urandom_range(1) ? CSR_W'(MAX_DIM) : 16'hFFFF) : pick_size();
         dh = far ? ($urandom_range(1) ? CSR_W'(MAX_DIM) : 16'h1FFF) : pick_size();
         set_geometry(pick_offset(far), pick_offset(far), pick_size(), pick_size(), dw, dh);
         calm = (phase == 2);
         if (phase == 2 || phase == 6) hold_off_req = 1'b1;
         count = $urandom_range(20, 60);
         repeat (count) offer_random();
         sent += count;
         phase++;
      end
      calm = 1'b0;

      quiesce();
      if (board.mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
